@@ rtl/core/krt_pkg.sv @@
// Shared types, codes and helpers for the keyed record table.
package krt_pkg;

	localparam int unsigned CAPACITY_DEF = 128;

	typedef enum logic [2:0] {
		CMD_APPEND = 3'd0,
		CMD_FIND   = 3'd1,
		CMD_SETQ   = 3'd2,
		CMD_DELETE = 3'd3,
		CMD_TOTAL  = 3'd4
	} cmd_e;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_FULL = 2'd1,
		STAT_MISS = 2'd2
	} status_e;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_TOTAL
	} state_e;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [31:0] key;
		logic signed [31:0] price;
		logic signed [31:0] quantity;
	} request_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [6:0]         position;
		logic signed [31:0] found_price;
		logic signed [31:0] found_quantity;
		logic signed [63:0] total_value;
		logic [7:0]         used_entries;
	} result_t;

	typedef struct packed {
		logic signed [31:0] key;
		logic signed [31:0] price;
		logic signed [31:0] quantity;
	} rec_t;

	function automatic logic [6:0] pos7(logic [31:0] v);
		return v[6:0];
	endfunction

	function automatic logic [7:0] used8(logic [31:0] v);
		return v[7:0];
	endfunction

endpackage

@@ rtl/core/krt_store.sv @@
// Record memory: one write port, one read port with registered read data.
module krt_store
	import krt_pkg::*;
#(
	parameter int unsigned DEPTH = CAPACITY_DEF,
	parameter int unsigned IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  rec_t          wdata,
	input  logic          re,
	input  logic [IW-1:0] raddr,
	output rec_t          rdata
);

	rec_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/krt_mac.sv @@
// Multiply and saturating accumulate unit for the table total.
module krt_mac
	import krt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               clr,
	input  logic               in_valid,
	input  logic signed [31:0] price,
	input  logic signed [31:0] quantity,
	output logic               busy,
	output logic signed [63:0] acc
);

	localparam logic signed [63:0] SAT_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] SAT_MIN = {1'b1, {63{1'b0}}};

	logic signed [63:0] prod_s1;
	logic               pvalid_s1;
	logic signed [63:0] acc_q;
	logic signed [63:0] sum;
	logic               ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvalid_s1 <= 1'b0;
		end else begin
			pvalid_s1 <= in_valid && !clr;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 64'(price) * 64'(quantity);
	end

	assign sum = acc_q + prod_s1;
	assign ovf = (acc_q[63] == prod_s1[63]) && (sum[63] != acc_q[63]);

	always_ff @(posedge clk) begin
		if (clr) begin
			acc_q <= '0;
		end else if (pvalid_s1) begin
			// clamp at the signed limits, direction from the addend
			acc_q <= ovf ? (prod_s1[63] ? SAT_MIN : SAT_MAX) : sum;
		end
	end

	assign busy = pvalid_s1;
	assign acc  = acc_q;

endmodule

@@ rtl/core/keyed_record_table_unit.sv @@
// Keyed record table: sequencer, record memory and total accumulator.
//
//  channel   ports                 direction  beat taken when
//  command   start, busy, request  in         start && !busy
//  result    done, result          out        done (one cycle, no back-pressure)
//
// Append and unused commands give their result in the cycle after the command is taken.
// Find and set quantity walk the records from index 0 until a match or the end of the
// table (a miss). Delete scans to the match, then moves every later record down one per
// cycle. Total streams every record through one 32x32 multiplier and a 64-bit saturating
// adder. The single read port of the record memory sets the pace. Reset empties the table
// at once with no clearing pass. The receiver cannot stall; busy holds off new commands.
module keyed_record_table_unit
	import krt_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  request_t request,
	output logic     done,
	output result_t  result
);

	localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_CW = CW'(CAPACITY);

	state_e  state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] ptr_q;
	logic          rvalid_q;
	logic [IW-1:0] ridx_q;
	logic [2:0]    cmd_q;
	logic signed [31:0] key_q, qty_q;
	logic [IW-1:0] fpos_q;
	logic signed [31:0] fprice_q, fqty_q;
	logic          done_q;
	result_t       result_q, res_d;

	logic          accept, scan_more, hit, walk_end, fin;
	logic          wr_en, re;
	logic [IW-1:0] waddr, raddr;
	rec_t          wdata, rdata;
	logic          mac_clr, mac_in, mac_busy;
	logic signed [63:0] mac_acc;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign scan_more = (ptr_q < count_q);
	assign hit       = (state_q == ST_SCAN) && rvalid_q && (rdata.key == key_q);
	assign walk_end  = !scan_more && !rvalid_q;

	krt_store #(
		.DEPTH(CAPACITY),
		.IW   (IW)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	krt_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (mac_clr),
		.in_valid(mac_in),
		.price   (rdata.price),
		.quantity(rdata.quantity),
		.busy    (mac_busy),
		.acc     (mac_acc)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (request.cmd)
						CMD_FIND, CMD_SETQ, CMD_DELETE: state_d = ST_SCAN;
						CMD_TOTAL:                      state_d = ST_TOTAL;
						default:                        state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				if (hit) begin
					state_d = (cmd_q == CMD_DELETE) ? ST_SHIFT : ST_IDLE;
				end else if (walk_end) begin
					state_d = ST_IDLE;
				end
			end
			ST_SHIFT: begin
				if (walk_end) begin
					state_d = ST_IDLE;
				end
			end
			ST_TOTAL: begin
				if (walk_end && !mac_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		fin     = 1'b0;
		count_d = count_q;
		res_d   = '0;
		wr_en   = 1'b0;
		waddr   = ridx_q;
		wdata   = rdata;
		re      = 1'b0;
		raddr   = ptr_q[IW-1:0];
		mac_clr = 1'b0;
		mac_in  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (request.cmd)
						CMD_APPEND: begin
							fin = 1'b1;
							if (count_q == CAP_CW) begin
								res_d.status = STAT_FULL;
							end else begin
								wr_en          = 1'b1;
								waddr          = count_q[IW-1:0];
								wdata.key      = request.key;
								wdata.price    = request.price;
								wdata.quantity = request.quantity;
								count_d        = count_q + CW'(1);
								res_d.position = pos7(32'(count_q));
							end
						end
						CMD_FIND, CMD_SETQ, CMD_DELETE: ;
						CMD_TOTAL: mac_clr = 1'b1;
						default:   fin = 1'b1;
					endcase
				end
			end
			ST_SCAN: begin
				re = scan_more;
				if (hit) begin
					res_d.position       = pos7(32'(ridx_q));
					res_d.found_price    = rdata.price;
					res_d.found_quantity = rdata.quantity;
					if (cmd_q == CMD_SETQ) begin
						wr_en                = 1'b1;
						wdata.quantity       = qty_q;
						res_d.found_quantity = qty_q;
					end
					fin = (cmd_q != CMD_DELETE);
				end else if (walk_end) begin
					fin          = 1'b1;
					res_d.status = STAT_MISS;
				end
			end
			ST_SHIFT: begin
				re = scan_more;
				if (rvalid_q) begin
					// move the record just read down one slot
					wr_en = 1'b1;
					waddr = ridx_q - IW'(1);
				end
				if (walk_end) begin
					fin                  = 1'b1;
					count_d              = count_q - CW'(1);
					res_d.position       = pos7(32'(fpos_q));
					res_d.found_price    = fprice_q;
					res_d.found_quantity = fqty_q;
				end
			end
			ST_TOTAL: begin
				re     = scan_more;
				mac_in = rvalid_q;
				if (walk_end && !mac_busy) begin
					fin               = 1'b1;
					res_d.total_value = mac_acc;
				end
			end
			default: ;
		endcase
		res_d.used_entries = used8(32'(count_d));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			ptr_q    <= '0;
			rvalid_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= fin;
			if (state_q == ST_IDLE) begin
				ptr_q    <= '0;
				rvalid_q <= 1'b0;
			end else if (hit && cmd_q == CMD_DELETE) begin
				// restart the walk just above the removed record
				ptr_q    <= CW'(ridx_q) + CW'(1);
				rvalid_q <= 1'b0;
			end else begin
				if (scan_more) begin
					ptr_q <= ptr_q + CW'(1);
				end
				rvalid_q <= scan_more;
			end
		end
	end

	always_ff @(posedge clk) begin
		ridx_q <= ptr_q[IW-1:0];
		if (accept) begin
			cmd_q <= request.cmd;
			key_q <= request.key;
			qty_q <= request.quantity;
		end
		if (hit) begin
			fpos_q   <= ridx_q;
			fprice_q <= rdata.price;
			fqty_q   <= rdata.quantity;
		end
		if (fin) begin
			result_q <= res_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CW)
		else $error("record count above capacity");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result given while a command is still running");

	a_total_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TOTAL) |-> !wr_en)
		else $error("record memory written during total");

	a_delete_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT && state_d == ST_IDLE) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("delete did not drop one record");

endmodule

@@ test/keyed_record_table_unit_tb.sv @@
// Self-checking testbench for the keyed record table: directed table, fill and random traffic.
module keyed_record_table_unit_tb;
	import krt_pkg::*;

	localparam int unsigned CAP         = CAPACITY_DEF;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int unsigned RANDOM_ITEMS = 720;
	localparam int unsigned PHASE_LEN   = 180;
	localparam int unsigned TAIL_CYCLES = 8;

	// Command codes with no meaning to the block.
	localparam logic [2:0] CMD_UNUSED_A = 3'd5;
	localparam logic [2:0] CMD_UNUSED_B = 3'd6;
	localparam logic [2:0] CMD_UNUSED_C = 3'd7;

	localparam logic signed [31:0] W_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] W_MAX = 32'sh7fff_ffff;
	localparam logic signed [63:0] SUM_MAX = 64'sh7fff_ffff_ffff_ffff;
	localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;
	localparam int FILL_KEY_BASE = 1000;

	typedef struct {
		request_t req;
		bit       typed;
		result_t  want;
	} stim_row_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	request_t request = '0;
	logic     done;
	result_t  result;

	keyed_record_table_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	always #2 clk = ~clk;

	// Shadow copy of the record table.
	logic signed [31:0] rec_key [CAP];
	logic signed [31:0] rec_price [CAP];
	logic signed [31:0] rec_qty [CAP];
	int unsigned        rec_count = 0;

	result_t     pending_results[$];
	stim_row_t   directed_rows[$];
	logic signed [31:0] key_pool[16];

	int unsigned errors = 0;
	int unsigned results_checked = 0;
	int unsigned items_sent = 0;
	int unsigned cmd_seen[8];
	int unsigned miss_count = 0;
	int unsigned full_count = 0;
	int unsigned sat_count = 0;
	int unsigned max_fill = 0;
	int unsigned no_idle_left = 0;
	int unsigned cycle_count = 0;

	function automatic request_t mk_req(logic [2:0] cmd, logic signed [31:0] key,
			logic signed [31:0] price, logic signed [31:0] qty);
		request_t r;
		r.cmd = cmd;
		r.key = key;
		r.price = price;
		r.quantity = qty;
		return r;
	endfunction

	function automatic result_t mk_res(logic [1:0] status, logic [6:0] pos,
			logic signed [31:0] fp, logic signed [31:0] fq, logic signed [63:0] tot,
			logic [7:0] used);
		result_t r;
		r.status = status;
		r.position = pos;
		r.found_price = fp;
		r.found_quantity = fq;
		r.total_value = tot;
		r.used_entries = used;
		return r;
	endfunction

	// Apply one command to the shadow table and return the result it yields.
	function automatic result_t predict_table_outcome(request_t req);
		result_t     r;
		int unsigned idx;
		longint      acc;
		longint      prod;
		longint      p;
		longint      q;
		longint      sum;
		r = '0;
		case (req.cmd)
			CMD_APPEND: begin
				if (rec_count >= CAP) begin
					r.status = STAT_FULL;
					full_count++;
				end else begin
					rec_key[rec_count] = req.key;
					rec_price[rec_count] = req.price;
					rec_qty[rec_count] = req.quantity;
					r.position = 7'(rec_count);
					rec_count++;
				end
			end
			CMD_FIND, CMD_SETQ, CMD_DELETE: begin
				idx = rec_count;
				for (int i = 0; i < rec_count; i++) begin
					if (rec_key[i] == req.key) begin
						idx = i;
						break;
					end
				end
				if (idx == rec_count) begin
					r.status = STAT_MISS;
					miss_count++;
				end else begin
					if (req.cmd == CMD_SETQ)
						rec_qty[idx] = req.quantity;
					r.position = 7'(idx);
					r.found_price = rec_price[idx];
					r.found_quantity = rec_qty[idx];
					if (req.cmd == CMD_DELETE) begin
						for (int i = idx; i + 1 < rec_count; i++) begin
							rec_key[i] = rec_key[i + 1];
							rec_price[i] = rec_price[i + 1];
							rec_qty[i] = rec_qty[i + 1];
						end
						rec_count--;
					end
				end
			end
			CMD_TOTAL: begin
				acc = 0;
				for (int i = 0; i < rec_count; i++) begin
					p = rec_price[i];
					q = rec_qty[i];
					prod = p * q;
					sum = acc + prod;
					// clamp when both addends share a sign that the sum lost
					if (acc[63] == prod[63] && sum[63] != acc[63]) begin
						sum = acc[63] ? SUM_MIN : SUM_MAX;
						sat_count++;
					end
					acc = sum;
				end
				r.total_value = acc;
			end
			default: ;
		endcase
		r.used_entries = 8'(rec_count);
		if (rec_count > max_fill)
			max_fill = rec_count;
		return r;
	endfunction

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t mismatch %s: expected %h, got %h", $time, name, want, got);
			errors++;
		end
	endtask

	// Compare every result beat with the oldest expectation.
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result beat: %h", $time, result);
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				check_field("status", exp_r.status, result.status);
				check_field("position", exp_r.position, result.position);
				check_field("found_price", exp_r.found_price, result.found_price);
				check_field("found_quantity", exp_r.found_quantity, result.found_quantity);
				check_field("total_value", exp_r.total_value, result.total_value);
				check_field("used_entries", exp_r.used_entries, result.used_entries);
				results_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t timeout with %0d results outstanding", $time,
				pending_results.size());
			$display("status: fail");
			$finish;
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_idle_left > 0) begin
			no_idle_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			no_idle_left = $urandom_range(30, 60);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	// Present one command, hold it until taken, then idle for a random gap.
	task automatic send_item(request_t req, bit typed, result_t want);
		result_t     pred;
		int unsigned gap;
		logic [127:0] noise;
		@(negedge clk);
		start <= 1'b1;
		request <= req;
		do @(posedge clk); while (busy);
		pred = predict_table_outcome(req);
		pending_results.push_back(typed ? want : pred);
		cmd_seen[req.cmd]++;
		items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			noise = {$urandom, $urandom, $urandom, $urandom};
			start <= 1'b0;
			request <= noise[$bits(request_t)-1:0];
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Hold the sender until every outstanding result has arrived.
	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(0, 19))
			0: return W_MIN;
			1: return W_MAX;
			2: return 32'sd0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	function automatic request_t random_command(bit growing);
		int unsigned      r;
		logic [2:0]       cmd;
		logic signed [31:0] key;
		r = $urandom_range(0, 99);
		if (growing)
			cmd = r < 60 ? CMD_APPEND : r < 70 ? CMD_FIND : r < 78 ? CMD_SETQ :
				r < 86 ? CMD_DELETE : r < 96 ? CMD_TOTAL : CMD_UNUSED_A;
		else
			cmd = r < 8 ? CMD_APPEND : r < 25 ? CMD_FIND : r < 35 ? CMD_SETQ :
				r < 88 ? CMD_DELETE : r < 96 ? CMD_TOTAL : CMD_UNUSED_A;
		if (cmd == CMD_UNUSED_A)
			cmd = 3'($urandom_range(CMD_UNUSED_C, CMD_UNUSED_A));
		// mostly reuse a small pool of keys so searches hit
		key = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 15)];
		return mk_req(cmd, key, pick_word(), pick_word());
	endfunction

	initial begin
		for (int i = 0; i < 8; i++)
			cmd_seen[i] = 0;
		key_pool[0] = W_MIN;
		key_pool[1] = W_MAX;
		key_pool[2] = 32'sd0;
		key_pool[3] = -32'sd1;
		for (int i = 4; i < 16; i++)
			key_pool[i] = $urandom;

		// Directed rows: expectations typed in where they are plain.
		directed_rows.push_back('{mk_req(CMD_TOTAL, 5, 0, 0), 1'b1,
			mk_res(STAT_OK, 0, 0, 0, 0, 0)});
		directed_rows.push_back('{mk_req(CMD_FIND, 5, 0, 0), 1'b1,
			mk_res(STAT_MISS, 0, 0, 0, 0, 0)});
		directed_rows.push_back('{mk_req(CMD_SETQ, 5, 0, 9), 1'b1,
			mk_res(STAT_MISS, 0, 0, 0, 0, 0)});
		directed_rows.push_back('{mk_req(CMD_DELETE, 5, 0, 0), 1'b1,
			mk_res(STAT_MISS, 0, 0, 0, 0, 0)});
		directed_rows.push_back('{mk_req(CMD_APPEND, W_MIN, W_MIN, W_MIN), 1'b1,
			mk_res(STAT_OK, 0, 0, 0, 0, 1)});
		directed_rows.push_back('{mk_req(CMD_APPEND, W_MAX, W_MIN, W_MIN), 1'b1,
			mk_res(STAT_OK, 1, 0, 0, 0, 2)});
		directed_rows.push_back('{mk_req(CMD_APPEND, -1, W_MIN, W_MIN), 1'b1,
			mk_res(STAT_OK, 2, 0, 0, 0, 3)});
		directed_rows.push_back('{mk_req(CMD_TOTAL, 0, 0, 0), 1'b1,
			mk_res(STAT_OK, 0, 0, 0, SUM_MAX, 3)});
		directed_rows.push_back('{mk_req(CMD_APPEND, 7, W_MAX, W_MIN), 1'b1,
			mk_res(STAT_OK, 3, 0, 0, 0, 4)});
		directed_rows.push_back('{mk_req(CMD_TOTAL, 0, 0, 0), 1'b0, '0});
		directed_rows.push_back('{mk_req(CMD_APPEND, 7, 100, 3), 1'b1,
			mk_res(STAT_OK, 4, 0, 0, 0, 5)});
		directed_rows.push_back('{mk_req(CMD_FIND, 7, 0, 0), 1'b1,
			mk_res(STAT_OK, 3, W_MAX, W_MIN, 0, 5)});
		directed_rows.push_back('{mk_req(CMD_SETQ, 7, W_MIN, 0), 1'b1,
			mk_res(STAT_OK, 3, W_MAX, 0, 0, 5)});
		directed_rows.push_back('{mk_req(CMD_DELETE, W_MIN, 0, 0), 1'b1,
			mk_res(STAT_OK, 0, W_MIN, W_MIN, 0, 4)});
		directed_rows.push_back('{mk_req(CMD_FIND, 7, 0, 0), 1'b0, '0});
		directed_rows.push_back('{mk_req(CMD_UNUSED_A, W_MAX, W_MAX, W_MAX), 1'b1,
			mk_res(STAT_OK, 0, 0, 0, 0, 4)});
		directed_rows.push_back('{mk_req(CMD_UNUSED_B, 7, 1, 1), 1'b1,
			mk_res(STAT_OK, 0, 0, 0, 0, 4)});
		directed_rows.push_back('{mk_req(CMD_UNUSED_C, -1, -1, -1), 1'b1,
			mk_res(STAT_OK, 0, 0, 0, 0, 4)});
		directed_rows.push_back('{mk_req(CMD_DELETE, W_MAX, 0, 0), 1'b0, '0});
		directed_rows.push_back('{mk_req(CMD_TOTAL, 0, 0, 0), 1'b0, '0});
		directed_rows.push_back('{mk_req(CMD_DELETE, -1, 0, 0), 1'b0, '0});
		directed_rows.push_back('{mk_req(CMD_DELETE, 7, 0, 0), 1'b0, '0});
		directed_rows.push_back('{mk_req(CMD_DELETE, 7, 0, 0), 1'b0, '0});
		directed_rows.push_back('{mk_req(CMD_TOTAL, 0, 0, 0), 1'b1,
			mk_res(STAT_OK, 0, 0, 0, 0, 0)});

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
		drain_results();

		// Fill to capacity with large negative products, then probe the top slot.
		for (int i = 0; i < CAP; i++)
			send_item(mk_req(CMD_APPEND, FILL_KEY_BASE + i, W_MIN, W_MAX), 1'b0, '0);
		send_item(mk_req(CMD_APPEND, 1, 2, 3), 1'b1, mk_res(STAT_FULL, 0, 0, 0, 0, 8'(CAP)));
		send_item(mk_req(CMD_TOTAL, 0, 0, 0), 1'b1, mk_res(STAT_OK, 0, 0, 0, SUM_MIN, 8'(CAP)));
		send_item(mk_req(CMD_FIND, FILL_KEY_BASE + CAP - 1, 0, 0), 1'b1,
			mk_res(STAT_OK, 7'(CAP - 1), W_MIN, W_MAX, 0, 8'(CAP)));
		send_item(mk_req(CMD_DELETE, FILL_KEY_BASE + CAP - 1, 0, 0), 1'b1,
			mk_res(STAT_OK, 7'(CAP - 1), W_MIN, W_MAX, 0, 8'(CAP - 1)));
		// Empty from the front so each delete shifts the whole table.
		for (int i = 0; i < CAP - 1; i++)
			send_item(mk_req(CMD_DELETE, FILL_KEY_BASE + i, 0, 0), 1'b0, '0);
		drain_results();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			send_item(random_command(((n / PHASE_LEN) % 2) == 0), 1'b0, '0);
			if ($urandom_range(0, 99) == 0)
				drain_results();
		end
		drain_results();

		$display("ran %0d commands (append %0d, find %0d, set %0d, delete %0d, total %0d)",
			items_sent, cmd_seen[CMD_APPEND], cmd_seen[CMD_FIND], cmd_seen[CMD_SETQ],
			cmd_seen[CMD_DELETE], cmd_seen[CMD_TOTAL]);
		$display("checked %0d results: %0d misses, %0d full, %0d clamped sums, peak %0d records",
			results_checked, miss_count, full_count, sat_count, max_fill);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
